FILE: sv/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared widths, register indexes and reset values for the rolling weak
// checksum block and its port checker.
// ----------------------------------------------------------------------------
package rwc_pkg;

  // Default window store depth in bytes
  localparam int unsigned WINDOW_MAX_DEF = 4096;

  // Stream payload widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CSUM_W = 2 * SUM_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned WLEN_W     = 13;
  localparam int unsigned OFFS_W     = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CSUM_W-1:0]     csum_t;

  // Register indexes
  localparam cfg_idx_t REG_WINDOW_LEN  = 2'd0;
  localparam cfg_idx_t REG_BYTE_SIGNED = 2'd1;
  localparam cfg_idx_t REG_CHAR_OFFSET = 2'd2;

  // Register reset values
  localparam logic [WLEN_W-1:0] WLEN_RST   = 13'd2048;
  localparam logic              SIGNED_RST = 1'b1;
  localparam logic [OFFS_W-1:0] OFFS_RST   = 8'd0;

  // Map a byte to its summing term, modulo 2^16
  function automatic sum_t byte_term(byte_t b, logic is_signed, logic [OFFS_W-1:0] offs);
    sum_t ext;
    ext = {{(SUM_W-BYTE_W){is_signed & b[BYTE_W-1]}}, b};
    return ext + {{(SUM_W-OFFS_W){1'b0}}, offs};
  endfunction

endpackage

FILE: sv/rolling_weak_checksum.sv
// ----------------------------------------------------------------------------
// rolling_weak_checksum
// Rolling two-sum checksum over a sliding byte window held in a block RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | sink      | in_tvalid / in_tready | tdata: byte, tuser: restart
//  out_    | source    | out_tvalid/out_tready | tdata: checksum, tuser: valid
//  cfg_    | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word in, one word out, one word per cycle sustained while out_tready
//  stays high. The accepting edge reads the leaving byte from the window RAM
//  into the update stage; the sums and the output register are updated when
//  that stage advances. The sums are written back per advancing word, so
//  consecutive words chain through the sum registers; the RAM is read-first,
//  so the leaving byte of a full window comes out as its slot is overwritten.
//  Reset (rst_n low, synchronous) clears sums, fill count, pointer and the
//  pipeline; the window RAM is not cleared. No clearing pass.
//  A stalled output holds the pipeline; in_tready drops once the update
//  stage is occupied as well. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rolling_weak_checksum #(
  parameter int unsigned WINDOW_MAX = rwc_pkg::WINDOW_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rwc_pkg::byte_t    in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] restart
  // result words
  output logic              out_tvalid,
  input  logic              out_tready,
  output rwc_pkg::csum_t    out_tdata,  // [15:0] sum_low, [31:16] sum_high
  output logic              out_tuser,  // [0] checksum_valid
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  rwc_pkg::cfg_idx_t cfg_index,
  input  rwc_pkg::cfg_data_t cfg_data
);
  import rwc_pkg::*;

  localparam int unsigned AW   = $clog2(WINDOW_MAX);
  localparam int unsigned LENW = AW + 1;
  localparam int unsigned PW   = LENW + SUM_W;

  // Configuration registers
  logic [WLEN_W-1:0] wlen_r;
  logic              bsigned_r;
  logic [OFFS_W-1:0] offs_r;

  // Window RAM
  byte_t             win_mem [WINDOW_MAX];
  byte_t             rd_byte_r;

  // Stream state
  logic [LENW-1:0]   fill_r, fill_nxt, fill_eff;
  logic [AW-1:0]     wp_r, wp_nxt, rd_idx;
  sum_t              s1_r, s2_r;

  // Update stage
  logic              p1_valid_r;
  sum_t              p1_term_r;
  logic              p1_rst_r;
  logic              p1_roll_r;
  logic              p1_flag_r;

  // Output register
  logic              out_valid_r;
  csum_t             out_data_r;
  logic              out_flag_r;

  logic              in_fire, adv, p1_fire, roll0;
  logic [LENW-1:0]   len;
  sum_t              s1_base, s2_base, u_term, lu, s1_new, s2_new;
  logic [PW-1:0]     lu_prod;

  assign cfg_ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_RST;
      bsigned_r <= SIGNED_RST;
      offs_r    <= OFFS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEN:  wlen_r    <= cfg_data[WLEN_W-1:0];
        REG_BYTE_SIGNED: bsigned_r <= cfg_data[0];
        REG_CHAR_OFFSET: offs_r    <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the window length to 1..WINDOW_MAX
  always_comb begin
    if (wlen_r == '0) begin
      len = LENW'(1);
    end else if (32'(wlen_r) > 32'(WINDOW_MAX)) begin
      len = LENW'(WINDOW_MAX);
    end else begin
      len = LENW'(wlen_r);
    end
  end

  // Handshake: the pipeline moves when the output register is free
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !p1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;
  assign p1_fire   = p1_valid_r && adv;

  // Fill count and write pointer advance at acceptance
  always_comb begin
    fill_eff = in_tuser ? '0 : fill_r;
    roll0    = (fill_eff >= len);
    fill_nxt = roll0 ? fill_eff : fill_eff + LENW'(1);
    if (32'(wp_r) == 32'(WINDOW_MAX - 1)) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + AW'(1);
    end
    // Slot of the byte that leaves the window
    if (LENW'(wp_r) >= len) begin
      rd_idx = AW'(LENW'(wp_r) - len);
    end else begin
      rd_idx = AW'(LENW'(wp_r) + LENW'(WINDOW_MAX) - len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wp_r   <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
      wp_r   <= wp_nxt;
    end
  end

  // Read the leaving byte and store the new one (read-first)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_byte_r       <= win_mem[rd_idx];
      win_mem[wp_r]   <= in_tdata;
    end
  end

  // Carry the word into the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_tready) begin
      p1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_term_r <= byte_term(in_tdata, bsigned_r, offs_r);
      p1_rst_r  <= in_tuser;
      p1_roll_r <= roll0;
      p1_flag_r <= (fill_nxt >= len);
    end
  end

  // Sum update: fill adds the new term, roll swaps the leaving one out
  always_comb begin
    s1_base = p1_rst_r ? '0 : s1_r;
    s2_base = p1_rst_r ? '0 : s2_r;
    u_term  = byte_term(rd_byte_r, bsigned_r, offs_r);
    lu_prod = PW'(len) * PW'(u_term);
    lu      = lu_prod[SUM_W-1:0];
    if (p1_roll_r) begin
      s1_new = s1_base - u_term + p1_term_r;
      s2_new = s2_base - lu + s1_new;
    end else begin
      s1_new = s1_base + p1_term_r;
      s2_new = s2_base + s1_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (p1_fire) begin
      s1_r <= s1_new;
      s2_r <= s2_new;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_fire) begin
      out_data_r <= {s2_new, s1_new};
      out_flag_r <= p1_flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

endmodule

FILE: sv/rwc_checker.sv
// ----------------------------------------------------------------------------
// rwc_checker
// Port-level checks on the rolling weak checksum block, bound to its top.
// ----------------------------------------------------------------------------
module rwc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input rwc_pkg::csum_t     out_tdata,
  input logic               out_tuser
);
  import rwc_pkg::*;

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // A free output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // An accepted word reaches the output if the sink is ready while it is in the update stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result word missing after accepted word");

  // Hold a stalled result word
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

endmodule

bind rolling_weak_checksum rwc_checker u_rwc_checker (.*);

FILE: sim/rwc_sum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rwc_sum_checker
// Port-level checker for the rolling weak checksum block. Watches the input,
// result and register channels, keeps its own window store, sums and
// register copies, predicts one checksum word per accepted input word and
// compares each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module rwc_sum_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  rwc_pkg::byte_t     in_tdata,   // [7:0] data_byte
  input  logic               in_tuser,   // [0] restart
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  rwc_pkg::csum_t     out_tdata,  // [15:0] sum_low, [31:16] sum_high
  input  logic               out_tuser,  // [0] checksum_valid
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  rwc_pkg::cfg_idx_t  cfg_index,
  input  rwc_pkg::cfg_data_t cfg_data,
  output int                 mismatches,
  output int                 words_due,
  output int                 words_checked,
  output int                 full_words
);
  import rwc_pkg::*;

  typedef struct packed {
    csum_t csum;
    logic  full;
  } csum_word_t;

  csum_word_t        due_q[$];
  byte_t             window_mem [WINDOW_MAX_DEF];
  sum_t              s_lo;
  sum_t              s_hi;
  int unsigned       fill_cnt;
  int unsigned       wr_ptr;
  logic [WLEN_W-1:0] wlen;
  logic              signed_mode;
  logic [OFFS_W-1:0] offs;

  initial begin
    mismatches    = 0;
    words_due     = 0;
    words_checked = 0;
    full_words    = 0;
  end

  // Summing term of a byte: widen (sign or zero), add the offset, wrap at 16 bits
  function automatic sum_t byte_weight(byte_t b);
    sum_t w;
    w = {8'h00, b};
    if (signed_mode && b[BYTE_W-1]) w[SUM_W-1:BYTE_W] = '1;
    return w + sum_t'(offs);
  endfunction

  // Take one byte into the window and produce the checksum word it causes
  task automatic advance(input byte_t b, input logic rs, output csum_word_t res);
    int unsigned span;
    int unsigned idx;
    sum_t        w;
    sum_t        u;
    sum_t        lu;
    // zero acts as one, anything above the store depth saturates
    span = (wlen == 0) ? 1 : ((wlen > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : wlen);
    w = byte_weight(b);
    if (rs) begin
      s_lo     = '0;
      s_hi     = '0;
      fill_cnt = 0;
    end
    if (fill_cnt < span) begin
      s_lo = s_lo + w;
      s_hi = s_hi + s_lo;
      fill_cnt++;
    end else begin
      // drop the byte written span words ago, add the new one
      idx  = (wr_ptr + WINDOW_MAX_DEF - span) % WINDOW_MAX_DEF;
      u    = byte_weight(window_mem[idx]);
      lu   = sum_t'(span * u);
      s_lo = s_lo - u + w;
      s_hi = s_hi - lu + s_lo;
    end
    window_mem[wr_ptr] = b;
    wr_ptr   = (wr_ptr + 1) % WINDOW_MAX_DEF;
    res.csum = {s_hi, s_lo};
    res.full = (fill_cnt >= span);
  endtask

  task automatic report(input string what, input csum_word_t e, input csum_t got_csum,
                        input logic got_full);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %0s: expected csum %h full %b, got csum %h full %b",
               $time, what, e.csum, e.full, got_csum, got_full);
  endtask

  // Follow every handshake at the rising edge
  always @(posedge clk) begin
    csum_word_t e;
    if (!rst_n) begin
      due_q.delete();
      s_lo        = '0;
      s_hi        = '0;
      fill_cnt    = 0;
      wr_ptr      = 0;
      wlen        = WLEN_RST;
      signed_mode = SIGNED_RST;
      offs        = OFFS_RST;
      foreach (window_mem[i]) window_mem[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEN:  wlen = cfg_data[WLEN_W-1:0];
          REG_BYTE_SIGNED: signed_mode = cfg_data[0];
          REG_CHAR_OFFSET: offs = cfg_data[OFFS_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          report("result word with nothing expected", '0, out_tdata, out_tuser);
        end else begin
          e = due_q.pop_front();
          words_checked++;
          if (e.full) full_words++;
          if (e.csum !== out_tdata || e.full !== out_tuser)
            report("checksum word mismatch", e, out_tdata, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        advance(in_tdata, in_tuser, e);
        due_q.push_back(e);
      end
    end
    words_due = due_q.size();
  end

endmodule

FILE: sim/tb_rolling_weak_checksum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_weak_checksum
// Drives byte words and register writes into the rolling weak checksum block
// under three pacing modes (slow sender, slow receiver, full rate) and
// reports the verdict from the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_rolling_weak_checksum;
  import rwc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_tvalid  = 1'b0;
  logic      in_tready;
  byte_t     in_tdata   = '0;
  logic      in_tuser   = 1'b0;
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  csum_t     out_tdata;
  logic      out_tuser;
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index  = REG_WINDOW_LEN;
  cfg_data_t cfg_data   = '0;

  int mismatches;
  int words_due;
  int words_checked;
  int full_words;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  always #1 clk = ~clk;

  rolling_weak_checksum DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rwc_sum_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .words_checked (words_checked),
    .full_words    (full_words)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding", cycles, words_due);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Write one register; called at a falling edge, returns at a falling edge
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  // Offer one byte word, with random gaps ahead of it
  task automatic send_word(input byte_t b, input logic rs);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = rs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold until every predicted word has come back, then let the pipe settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random register setting; upper data bits of the sign and offset writes are junk to check they get dropped
  task automatic pick_setting(output int wl);
    case ($urandom_range(5))
      0:       wl = 0;
      1:       wl = 1;
      2:       wl = $urandom_range(2, 8);
      3:       wl = $urandom_range(9, 64);
      4:       wl = $urandom_range(65, 400);
      default: wl = $urandom_range(4097, 8191);
    endcase
    write_reg(REG_WINDOW_LEN, cfg_data_t'(wl));
    write_reg(REG_BYTE_SIGNED, cfg_data_t'($urandom_range(0, 8191)));
    case ($urandom_range(3))
      0:       write_reg(REG_CHAR_OFFSET, {5'($urandom), 8'h00});
      1:       write_reg(REG_CHAR_OFFSET, {5'($urandom), 8'hff});
      default: write_reg(REG_CHAR_OFFSET, {5'($urandom), 8'($urandom)});
    endcase
  endtask

  initial begin
    int wl;
    int n;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: short signed window, byte extremes, restart on first word and mid-stream
    write_reg(REG_WINDOW_LEN, 13'd4);
    write_reg(REG_BYTE_SIGNED, 13'd1);
    write_reg(REG_CHAR_OFFSET, 13'd0);
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'haa, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h7f, 1'b0);
    drain();

    // Zero length acts as one; shrink the window mid-stream, unsigned, top offset
    write_reg(REG_WINDOW_LEN, 13'd0);
    write_reg(REG_BYTE_SIGNED, 13'd0);
    write_reg(REG_CHAR_OFFSET, 13'd255);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h7f, 1'b0);
    drain();

    // Grow the window mid-stream: filling resumes
    write_reg(REG_WINDOW_LEN, 13'd6);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hfe, 1'b0);
    drain();

    // Random: slow receiver, then slow sender, then full rate
    for (int mode = 0; mode < 3; mode++) begin
      in_gap_pct    = (mode == 0) ? 27 : ((mode == 1) ? 74 : 0);
      out_stall_pct = (mode == 0) ? 74 : ((mode == 1) ? 27 : 0);
      for (int seg = 0; seg < 6; seg++) begin
        pick_setting(wl);
        n = $urandom_range(30, 100) + ((wl <= 400) ? wl : 0);
        for (int i = 0; i < n; i++)
          send_word(8'($urandom), (i == 0) ? 1'($urandom) : ($urandom_range(99) == 0));
        drain();
      end
    end

    // Saturated length at full rate: the window keeps filling
    write_reg(REG_WINDOW_LEN, 13'h1fff);
    write_reg(REG_BYTE_SIGNED, 13'd1);
    write_reg(REG_CHAR_OFFSET, cfg_data_t'($urandom_range(1, 255)));
    for (int i = 0; i < 256; i++)
      send_word(8'($urandom), i == 0);
    drain();
    repeat (10) @(negedge clk);

    $display("Covered %0d checksum words, %0d of them over a full window, with %0d register",
             words_checked, full_words, cfg_writes);
    $display("writes across window lengths from zero to saturation and three pacing modes");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: rolling_weak_checksum.f
sv/rwc_pkg.sv
sv/rolling_weak_checksum.sv
sv/rwc_checker.sv
sim/rwc_sum_checker.sv
sim/tb_rolling_weak_checksum.sv
